### hw/rtl/edd_pkg.sv
// Shared types and constants for the error diffusion dither block.
// Used by every module under hw/rtl; depends on nothing else.
package edd_pkg;

    localparam int EDD_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int GREY_W     = 8;
    localparam int ERR_W      = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    localparam logic signed [9:0] THRESHOLD   = 10'sd128;
    localparam logic signed [9:0] WHITE_LEVEL = 10'sd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Position flags of a pixel, fixed when it is accepted.
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic first_row;
        logic col_zero;
    } t_pos;

    // Line buffer write request from the diffusion stage.
    typedef struct packed {
        logic                    pri_en;
        logic                    tail_en;
        logic signed [ERR_W-1:0] pri_data;
        logic signed [ERR_W-1:0] tail_data;
    } t_wr_req;

endpackage

### hw/rtl/edd_front.sv
// Input stage: configuration registers, raster position counters and the
// input register. Depends on edd_pkg.
module edd_front import edd_pkg::*; #(
    parameter int MAX_WIDTH = EDD_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [GREY_W-1:0]     i_grey_in,
    input  logic                  i_move,
    output logic                  o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] o_rd_addr,
    output logic                  o_a_valid,
    output logic [GREY_W-1:0]     o_a_grey,
    output t_pos                  o_a_pos,
    output logic [$clog2(MAX_WIDTH)-1:0] o_a_col
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [AW-1:0]       r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_a_valid;
    logic [GREY_W-1:0]   r_a_grey;
    t_pos                r_a_pos;
    logic [AW-1:0]       r_a_col;

    logic [XW-1:0]       w_lim;
    logic [HEIGHT_W-1:0] h_lim;
    logic                accept;
    t_pos                n_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
            endcase
        end
    end

    // A zero dimension counts as one; larger values saturate at the maximum.
    always_comb begin
        if (r_width == '0) begin
            w_lim = XW'(1);
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            w_lim = XW'(MAX_WIDTH);
        end else begin
            w_lim = XW'(r_width);
        end
        if (r_height == '0) begin
            h_lim = HEIGHT_W'(1);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_lim = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_lim = r_height;
        end
    end

    assign n_pos.last_col  = XW'(r_col) >= (w_lim - XW'(1));
    assign n_pos.last_row  = HEIGHT_W'(r_row) >= (h_lim - HEIGHT_W'(1));
    assign n_pos.first_row = (r_row == '0);
    assign n_pos.col_zero  = (r_col == '0);

    assign o_in_stall = r_a_valid && !i_move;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                if (n_pos.last_col) begin
                    r_col <= '0;
                    r_row <= n_pos.last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (i_move) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_grey <= i_grey_in;
            r_a_pos  <= n_pos;
            r_a_col  <= r_col;
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_col;
    assign o_a_valid = r_a_valid;
    assign o_a_grey  = r_a_grey;
    assign o_a_pos   = r_a_pos;
    assign o_a_col   = r_a_col;

`ifndef SYNTHESIS
    a_col_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_pos.last_col |=> r_col == '0)
        else $error("column counter did not restart after the last column");
`endif

endmodule

### hw/rtl/edd_linebuf.sv
// Line buffer of weighted error sums for the next row, with a held row-end
// entry and read bypass of same-cycle and held writes. Depends on edd_pkg.
module edd_linebuf import edd_pkg::*; #(
    parameter int MAX_WIDTH = EDD_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_col,
    input  t_wr_req                       i_wr,
    output logic signed [ERR_W-1:0]       o_rd_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic signed [ERR_W-1:0] r_mem [MAX_WIDTH];
    logic signed [ERR_W-1:0] r_mem_q;
    logic                    r_byp_vld;
    logic signed [ERR_W-1:0] r_byp_data;
    logic                    r_tail_vld;
    logic [AW-1:0]           r_tail_addr;
    logic signed [ERR_W-1:0] r_tail_data;

    logic [AW-1:0]           pri_addr;
    logic                    n_byp_vld;
    logic signed [ERR_W-1:0] n_byp_data;

    assign pri_addr = i_wr_col - 1'b1;

    // The row-end entry is held aside and goes to memory in the first cycle
    // that carries no other write.
    always_ff @(posedge i_clk) begin
        if (i_wr.pri_en) begin
            r_mem[pri_addr] <= i_wr.pri_data;
        end else if (r_tail_vld) begin
            r_mem[r_tail_addr] <= r_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_vld <= 1'b0;
        end else if (i_wr.tail_en) begin
            r_tail_vld <= 1'b1;
        end else if (!i_wr.pri_en) begin
            r_tail_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.tail_en) begin
            r_tail_addr <= i_wr_col;
            r_tail_data <= i_wr.tail_data;
        end
    end

    // Newest data wins: a row-end entry written now, then a plain write now,
    // then a row-end entry still held.
    always_comb begin
        n_byp_vld  = 1'b1;
        n_byp_data = r_tail_data;
        if (i_wr.tail_en && i_wr_col == i_rd_addr) begin
            n_byp_data = i_wr.tail_data;
        end else if (i_wr.pri_en && pri_addr == i_rd_addr) begin
            n_byp_data = i_wr.pri_data;
        end else if (r_tail_vld && r_tail_addr == i_rd_addr) begin
            n_byp_data = r_tail_data;
        end else begin
            n_byp_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q    <= r_mem[i_rd_addr];
            r_byp_vld  <= n_byp_vld;
            r_byp_data <= n_byp_data;
        end
    end

    assign o_rd_data = r_byp_vld ? r_byp_data : r_mem_q;

`ifndef SYNTHESIS
    a_no_tail_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.pri_en && r_tail_vld))
        else $error("row-end entry still held when a plain write arrives");

    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.tail_en |=> r_tail_vld && r_tail_addr == $past(i_wr_col))
        else $error("row-end entry not held after its write");
`endif

endmodule

### hw/rtl/edd_core.sv
// Diffusion stage: corrects the pixel, thresholds it, spreads its error and
// holds the result register. Depends on edd_pkg.
module edd_core import edd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_a_valid,
    input  logic [GREY_W-1:0]       i_a_grey,
    input  t_pos                    i_a_pos,
    input  logic signed [ERR_W-1:0] i_rd_data,
    input  logic                    i_out_stall,
    output logic                    o_move,
    output t_wr_req                 o_wr,
    output logic                    o_out_valid,
    output logic                    o_bit_out,
    output logic                    o_row_end,
    output logic                    o_frame_end
);

    logic signed [ERR_W-1:0] r_right;
    logic signed [ERR_W-1:0] r_below;
    logic signed [ERR_W-1:0] r_diag;
    logic                    r_out_valid;
    logic                    r_bit;
    logic                    r_row_end;
    logic                    r_frame_end;

    logic signed [ERR_W-1:0] total;
    logic signed [8:0]       corr;
    logic signed [9:0]       v;
    logic                    white;
    logic signed [8:0]       err;
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e3;
    logic signed [ERR_W-1:0] e5;
    logic signed [ERR_W-1:0] e7;
    logic signed [ERR_W-1:0] n_below;

    assign o_move = i_a_valid && (!r_out_valid || !i_out_stall);

    // The first row of a frame has nothing diffused from above.
    assign total = r_right + (i_a_pos.first_row ? ERR_W'(0) : i_rd_data);
    assign corr  = 9'(total >>> 4);
    assign v     = $signed({2'b00, i_a_grey}) + 10'(corr);
    assign white = (v >= THRESHOLD);
    assign err   = 9'(white ? v - WHITE_LEVEL : v);

    assign e1      = ERR_W'(err);
    assign e3      = (e1 <<< 1) + e1;
    assign e5      = (e1 <<< 2) + e1;
    assign e7      = (e1 <<< 3) - e1;
    assign n_below = r_diag + e5;

    // The last row of a frame sends nothing downward.
    assign o_wr.pri_en    = o_move && !i_a_pos.last_row && !i_a_pos.col_zero;
    assign o_wr.pri_data  = r_below + e3;
    assign o_wr.tail_en   = o_move && !i_a_pos.last_row && i_a_pos.last_col;
    assign o_wr.tail_data = n_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_below <= '0;
            r_diag  <= '0;
        end else if (o_move) begin
            r_right <= i_a_pos.last_col ? ERR_W'(0) : e7;
            if (i_a_pos.last_col) begin
                r_below <= '0;
                r_diag  <= '0;
            end else if (!i_a_pos.last_row) begin
                r_below <= n_below;
                r_diag  <= e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_bit       <= white;
            r_row_end   <= i_a_pos.last_col;
            r_frame_end <= i_a_pos.last_col && i_a_pos.last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bit_out   = r_bit;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

`ifndef SYNTHESIS
    a_row_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_move && i_a_pos.last_col |=> r_right == '0 && r_below == '0 && r_diag == '0)
        else $error("carries not cleared at the end of a row");

    a_frame_on_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_end |-> r_row_end)
        else $error("frame end flagged on a pixel that does not end a row");
`endif

endmodule

### hw/rtl/error_diffusion_dither.sv
// Floyd-Steinberg error diffusion dither, top level.
// Grey pixels arrive in raster order on the input channel (i_in_valid,
// o_in_stall, i_grey_in); one black or white bit per pixel leaves on the
// output channel (o_out_valid, i_out_stall) with row and frame end flags.
// A request is taken at a rising edge with valid high and stall low.
// Image width and height are written through the configuration channel
// (index 0 width, index 1 height) while no pixel is in flight; the user is
// bound to this; the block itself does not enforce it. A pixel goes from the
// input register to the result register. Throughput is one pixel per clock
// while the receiver does not stall, set by the single pass from the input
// register through the diffusion logic to the result register; the
// right-neighbour error feeds back in that same cycle. When the receiver
// stalls, the result holds and one more pixel waits in the input register;
// beyond that o_in_stall rises. Reset sets 640 by 480, returns to the first
// pixel of a frame and clears the carries. The line buffer is not cleared
// and needs no clearing pass: the first row of a frame ignores its reads.
// Depends on edd_pkg, edd_front, edd_linebuf and edd_core.
module error_diffusion_dither import edd_pkg::*; #(
    parameter int MAX_WIDTH = EDD_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [GREY_W-1:0]     i_grey_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_bit_out,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                    move;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    a_valid;
    logic [GREY_W-1:0]       a_grey;
    t_pos                    a_pos;
    logic [AW-1:0]           a_col;
    logic signed [ERR_W-1:0] rd_data;
    t_wr_req                 wr;

    edd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_grey_in   (i_grey_in),
        .i_move      (move),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_a_valid   (a_valid),
        .o_a_grey    (a_grey),
        .o_a_pos     (a_pos),
        .o_a_col     (a_col)
    );

    edd_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_col  (a_col),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    edd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_a_valid   (a_valid),
        .i_a_grey    (a_grey),
        .i_a_pos     (a_pos),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_move      (move),
        .o_wr        (wr),
        .o_out_valid (o_out_valid),
        .o_bit_out   (o_bit_out),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

endmodule
